FILE: hw/rtl/fir_dec_pkg.sv
`default_nettype none

package fir_dec_pkg;

    localparam int DECIMATION   = 2;
    localparam int TAPS         = 16;
    localparam int SAMPLE_WIDTH = 24;
    localparam int COEF_WIDTH   = 18;
    localparam int COEF_FRAC    = 17;
    localparam int NCOEF        = TAPS / 2;

    localparam int ADDR_W    = $clog2(TAPS);
    localparam int CIDX_W    = $clog2(NCOEF);
    localparam int CFG_IDX_W = 8;
    localparam int WARM_W    = $clog2(TAPS + 1);
    localparam int PHASE_W   = (DECIMATION > 2) ? $clog2(DECIMATION) : 1;
    localparam int PRE_W     = SAMPLE_WIDTH + 1;
    localparam int PROD_W    = PRE_W + COEF_WIDTH;
    localparam int ACC_W     = PROD_W + CIDX_W + 1;
    localparam int RND_W     = ACC_W - COEF_FRAC;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;

    localparam coef_t COEF_RESET [NCOEF] = '{
        -18'sd170, -18'sd275, 18'sd629, 18'sd1534,
        -18'sd2897, -18'sd5125, 18'sd8703, 18'sd17013
    };

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } step_t;

    typedef struct packed {
        step_t             step;
        logic [CIDX_W-1:0] k;
    } rd_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DRAIN,
        ST_OUT
    } seq_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fir_decimator_16tap_top.sv
// 16-tap symmetric fir decimator, one shared pre-add/multiply/accumulate unit
// s_* channel: one beat is one signed q1.23 input sample
// m_* channel: one beat is one filtered, rounded and saturated q1.23 sample
// cfg_* channel: index 0..7 writes the q1.17 coefficient of taps k and 15-k,
//   other indexes are ignored; always ready, write only while idle
// the first result follows the 16th input sample, then one per 2 inputs
// a beat that produces no result leaves s_tready high
// a beat that produces a result holds s_tready low: the 8 pair reads from the
//   history ram (two read ports) pass through the registered read, the
//   multiplier and the accumulator, then the finished sum is loaded into the
//   output register and m_tvalid rises
// the output register holds a finished result while new samples are taken in;
//   if the receiver stalls, the next result waits in the accumulator and the
//   input side stays not ready until the output register frees up
// reset clears history (reads as zero), counters and output valid, and loads
//   the default coefficient set
`default_nettype none

module fir_decimator_16tap_top
    import fir_dec_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [SAMPLE_WIDTH-1:0] s_tdata,   // [23:0] in_sample
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [SAMPLE_WIDTH-1:0]    m_tdata,     // [23:0] out_sample
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [COEF_WIDTH-1:0] cfg_data
);

    rd_req_t req;
    rd_req_t rsp;
    sample_t tap_a;
    sample_t tap_b;
    coef_t   coef;
    sample_t result;
    logic    wr_en;
    logic    mac_done;
    logic    out_free;
    logic    load_out;
    logic    m_tvalid_reg;
    sample_t m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    fir_dec_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .wr_en    (wr_en),
        .req      (req),
        .mac_done (mac_done),
        .out_free (out_free),
        .load_out (load_out)
    );

    fir_dec_hist u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (sample_t'(s_tdata)),
        .req     (req),
        .tap_a   (tap_a),
        .tap_b   (tap_b),
        .rsp     (rsp)
    );

    fir_dec_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rd_idx    (rsp.k),
        .rd_coef   (coef)
    );

    fir_dec_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .tap_a  (tap_a),
        .tap_b  (tap_b),
        .coef   (coef),
        .step   (rsp.step),
        .result (result),
        .done   (mac_done)
    );

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_tdata_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/fir_dec_regs.sv
`default_nettype none

module fir_dec_regs
    import fir_dec_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COEF_WIDTH-1:0] cfg_data,
    input  wire logic [CIDX_W-1:0]    rd_idx,
    output coef_t                     rd_coef
);

    coef_t coef_reg [NCOEF];
    logic  wr_hit;

    assign cfg_ready = 1'b1;
    // indexes past the coefficient list are dropped
    assign wr_hit    = cfg_valid && (cfg_index < CFG_IDX_W'(NCOEF));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCOEF; i++)
            begin
                coef_reg[i] <= COEF_RESET[i];
            end
        end
        else if (wr_hit)
        begin
            coef_reg[cfg_index[CIDX_W-1:0]] <= coef_t'(cfg_data);
        end
    end

    assign rd_coef = coef_reg[rd_idx];

endmodule

`default_nettype wire

FILE: hw/rtl/fir_dec_hist.sv
`default_nettype none

module fir_dec_hist
    import fir_dec_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire sample_t wr_data,
    input  wire rd_req_t req,
    output sample_t      tap_a,
    output sample_t      tap_b,
    output rd_req_t      rsp
);

    sample_t           mem [TAPS];
    logic [TAPS-1:0]   valid_reg;
    logic [ADDR_W-1:0] wp_reg;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    sample_t           rd_a_reg;
    sample_t           rd_b_reg;
    logic              vld_a_reg;
    logic              vld_b_reg;
    rd_req_t           rsp_reg;

    // wp points at the oldest sample, tap 0; taps k and 15-k are read together
    assign addr_a = wp_reg + ADDR_W'(req.k);
    assign addr_b = wp_reg + (ADDR_W'(TAPS - 1) - ADDR_W'(req.k));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_data;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            wp_reg    <= '0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wp_reg] <= 1'b1;
                wp_reg            <= wp_reg + ADDR_W'(1);
            end
            vld_a_reg <= valid_reg[addr_a];
            vld_b_reg <= valid_reg[addr_b];
            rsp_reg   <= req;
        end
    end

    // entries not written since reset read as zero
    assign tap_a = vld_a_reg ? rd_a_reg : '0;
    assign tap_b = vld_b_reg ? rd_b_reg : '0;
    assign rsp   = rsp_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/fir_dec_mac.sv
`default_nettype none

module fir_dec_mac
    import fir_dec_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire sample_t tap_a,
    input  wire sample_t tap_b,
    input  wire coef_t   coef,
    input  wire step_t   step,
    output sample_t      result,
    output logic         done
);

    logic signed [PRE_W-1:0]  pre;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  biased;
    logic signed [RND_W-1:0]  rnd;
    step_t                    step2_reg;
    logic                     done_reg;
    logic                     in_range;

    // symmetric pre-add, then one shared multiplier
    assign pre       = {tap_a[SAMPLE_WIDTH-1], tap_a} + {tap_b[SAMPLE_WIDTH-1], tap_b};
    assign prod_next = pre * coef;
    assign prod_ext  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_next  = step2_reg.first ? prod_ext : acc_reg + prod_ext;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (step2_reg.vld)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step2_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            step2_reg <= step;
            done_reg  <= step2_reg.vld && step2_reg.last;
        end
    end

    // round half up, floor shift, clamp to sample range
    assign biased   = acc_reg + ACC_W'(1 << (COEF_FRAC - 1));
    assign rnd      = biased[ACC_W-1:COEF_FRAC];
    assign in_range = (&rnd[RND_W-1:SAMPLE_WIDTH-1]) || !(|rnd[RND_W-1:SAMPLE_WIDTH-1]);

    always_comb
    begin
        if (in_range)
        begin
            result = rnd[SAMPLE_WIDTH-1:0];
        end
        else if (rnd[RND_W-1])
        begin
            result = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/fir_dec_seq.sv
`default_nettype none

module fir_dec_seq
    import fir_dec_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      wr_en,
    output rd_req_t   req,
    input  wire logic mac_done,
    input  wire logic out_free,
    output logic      load_out
);

    seq_state_t         state_reg;
    seq_state_t         state_next;
    logic [CIDX_W-1:0]  cnt_reg;
    logic [CIDX_W-1:0]  cnt_next;
    logic [WARM_W-1:0]  warm_reg;
    logic [WARM_W-1:0]  warm_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic               accept;
    logic               emit;
    logic               last_pair;

    assign accept    = in_valid && in_ready;
    assign last_pair = (cnt_reg == CIDX_W'(NCOEF - 1));

    // warmup until the history is full, then one result per decimation period
    always_comb
    begin
        warm_next  = warm_reg;
        phase_next = phase_reg;
        emit       = 1'b0;
        if (warm_reg < WARM_W'(TAPS))
        begin
            warm_next = warm_reg + WARM_W'(1);
            if (warm_next == WARM_W'(TAPS))
            begin
                emit       = 1'b1;
                phase_next = '0;
            end
        end
        else if (({1'b0, phase_reg} + (PHASE_W+1)'(1)) >= (PHASE_W+1)'(DECIMATION))
        begin
            emit       = 1'b1;
            phase_next = '0;
        end
        else
        begin
            phase_next = phase_reg + PHASE_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept && emit)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cnt_next = cnt_reg + CIDX_W'(1);
                if (last_pair)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        load_out       = 1'b0;
        req.step.vld   = 1'b0;
        req.step.first = 1'b0;
        req.step.last  = 1'b0;
        req.k          = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_CALC:
            begin
                req.step.vld   = 1'b1;
                req.step.first = (cnt_reg == '0);
                req.step.last  = last_pair;
            end
            ST_DRAIN:
            begin
                in_ready = 1'b0;
            end
            ST_OUT:
            begin
                load_out = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign wr_en = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            warm_reg  <= '0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (accept)
            begin
                warm_reg  <= warm_next;
                phase_reg <= phase_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/fir_dec_tb_pkg.sv
`timescale 1ns / 100ps

package fir_dec_tb_pkg;

    import fir_dec_pkg::*;

    class fir_dec_scoreboard;

        coef_t       coefs [NCOEF];
        sample_t     history [TAPS];      // [0] is the oldest sample
        int unsigned warm_seen;
        int unsigned since_out;
        sample_t     filtered_q [$];

        int unsigned n_samples;
        int unsigned n_checked;
        int unsigned n_clamped;
        int unsigned n_errors;

        function new();
            coefs     = COEF_RESET;
            foreach (history[k])
                history[k] = '0;
            warm_seen = 0;
            since_out = 0;
            n_samples = 0;
            n_checked = 0;
            n_clamped = 0;
            n_errors  = 0;
        endfunction

        function void write_coef(logic [CFG_IDX_W-1:0] idx, coef_t value);
            if (idx < NCOEF)
                coefs[idx] = value;
        endfunction

        // symmetric 16-tap sum, q1.40 rounded half up to q1.23, then clamped
        function sample_t filtered_sample();
            longint acc;
            longint hi;
            longint lo;
            int     k;
            acc = 0;
            hi  = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
            lo  = -hi - 1;
            for (k = 0; k < NCOEF; k++)
                acc += (longint'(history[k]) + longint'(history[TAPS-1-k]))
                       * longint'(coefs[k]);
            acc = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
            if (acc > hi || acc < lo)
                n_clamped++;
            if (acc > hi)
                acc = hi;
            if (acc < lo)
                acc = lo;
            return sample_t'(acc);
        endfunction

        function void take_sample(sample_t smp);
            int k;
            bit emit;
            for (k = 0; k < TAPS - 1; k++)
                history[k] = history[k+1];
            history[TAPS-1] = smp;
            n_samples++;
            emit = 1'b0;
            if (warm_seen < TAPS)
            begin
                warm_seen++;
                if (warm_seen == TAPS)
                begin
                    emit      = 1'b1;
                    since_out = 0;
                end
            end
            else if (since_out + 1 >= DECIMATION)
            begin
                emit      = 1'b1;
                since_out = 0;
            end
            else
            begin
                since_out++;
            end
            if (emit)
                filtered_q.push_back(filtered_sample());
        endfunction

        function void check_sample(sample_t got);
            sample_t want;
            if (filtered_q.size() == 0)
            begin
                n_errors++;
                $error("out_sample: expected no beat, actual %0d", got);
                return;
            end
            want = filtered_q.pop_front();
            n_checked++;
            if (got !== want)
            begin
                n_errors++;
                $error("out_sample: expected %0d, actual %0d", want, got);
            end
        endfunction

        function int unsigned pending();
            return filtered_q.size();
        endfunction

        function void report_leftover();
            if (filtered_q.size() != 0)
            begin
                n_errors++;
                $error("out_sample: expected %0d more beats, actual none",
                       filtered_q.size());
            end
        endfunction

    endclass

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import fir_dec_pkg::*;
    import fir_dec_tb_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RST_CYCLES    = 12;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RAND_ITEMS    = 1250;
    localparam int RELOAD_EVERY  = 80;

    localparam int REG_COEF_FIRST   = 0;
    localparam int REG_COEF_LAST    = NCOEF - 1;
    localparam int REG_UNUSED_FIRST = NCOEF;
    localparam int REG_IDX_TOP      = (1 << CFG_IDX_W) - 1;

    localparam coef_t   COEF_MAX   = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam coef_t   COEF_MIN   = {1'b1, {(COEF_WIDTH-1){1'b0}}};
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    localparam int SRC_IDLE  [4] = '{0, 80, 0, 14};
    localparam int SNK_STALL [4] = '{0, 0, 80, 14};

    typedef enum int {
        COEFS_DEFAULT,
        COEFS_MAX,
        COEFS_MIN,
        COEFS_ALT,
        COEFS_SMALL,
        COEFS_RANDOM
    } coef_set_e;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [SAMPLE_WIDTH-1:0] s_tdata   = '0;    // [23:0] in_sample
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [SAMPLE_WIDTH-1:0] m_tdata;           // [23:0] out_sample
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [COEF_WIDTH-1:0]   cfg_data  = '0;

    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned n_loads       = 0;

    fir_dec_scoreboard filt_sb;

    fir_decimator_16tap_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99, 0) >= snk_stall_pct);

    // result check and watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (m_tvalid === 1'b1 && m_tready)
            filt_sb.check_sample(m_tdata);
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)
            || (cfg_valid && cfg_ready === 1'b1))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("FAIL fir_decimator_16tap_top");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic sample_t pick_sample();
        int unsigned sel;
        sel = $urandom_range(99, 0);
        if (sel < 10)
        begin
            case ($urandom_range(3, 0))
                0:       return SAMPLE_MAX;
                1:       return SAMPLE_MIN;
                2:       return sample_t'(0);
                default: return sample_t'(-1);
            endcase
        end
        else if (sel < 40)
        begin
            return sample_t'(int'($urandom_range(4095, 0)) - 2048);
        end
        return sample_t'($urandom);
    endfunction

    function automatic coef_t pick_coef(coef_set_e set, int k);
        case (set)
            COEFS_DEFAULT: return COEF_RESET[k];
            COEFS_MAX:     return COEF_MAX;
            COEFS_MIN:     return COEF_MIN;
            COEFS_ALT:     return k[0] ? COEF_MIN : COEF_MAX;
            COEFS_SMALL:   return coef_t'(int'($urandom_range(16383, 0)) - 8192);
            default:       return coef_t'($urandom);
        endcase
    endfunction

    // valid stays up between back-to-back beats, the caller drops it
    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input coef_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        filt_sb.write_coef(idx, value);
    endtask

    task automatic load_coefs(input coef_set_e set);
        int k;
        logic [CFG_IDX_W-1:0] stray_idx;
        for (k = REG_COEF_FIRST; k <= REG_COEF_LAST; k++)
            cfg_beat(CFG_IDX_W'(k), pick_coef(set, k));
        // a write past the coefficient bank must change nothing
        stray_idx = (n_loads == 0) ? CFG_IDX_W'(REG_IDX_TOP)
                  : CFG_IDX_W'($urandom_range(REG_IDX_TOP, REG_UNUSED_FIRST));
        cfg_beat(stray_idx, coef_t'($urandom));
        cfg_valid <= 1'b0;
        n_loads++;
    endtask

    task automatic send_sample(input sample_t smp);
        while ($urandom_range(99, 0) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= SAMPLE_WIDTH'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        filt_sb.take_sample(smp);
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (filt_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int ph;
        int n;
        filt_sb = new();
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // warmup on reset coefficients, first result only on the 16th beat
        send_sample(sample_t'(0));
        send_sample(sample_t'(1));
        send_sample(sample_t'(-1));
        send_sample(SAMPLE_MIN);
        repeat (12) send_sample(SAMPLE_MAX);

        // full-scale history against full-scale gain clamps at both ends
        wait_results_done();
        load_coefs(COEFS_MAX);
        repeat (4) send_sample(SAMPLE_MAX);
        wait_results_done();
        load_coefs(COEFS_MIN);
        repeat (2) send_sample(SAMPLE_MAX);
        wait_results_done();
        load_coefs(COEFS_ALT);
        repeat (4) send_sample(SAMPLE_MIN);

        for (ph = 0; ph < 4; ph++)
        begin
            src_idle_pct  = SRC_IDLE[ph];
            snk_stall_pct = SNK_STALL[ph];
            for (n = 0; n < RAND_ITEMS / 4; n++)
            begin
                if (n % RELOAD_EVERY == 0)
                begin
                    wait_results_done();
                    load_coefs(coef_set_e'(n_loads % (COEFS_RANDOM + 1)));
                end
                else if ($urandom_range(99, 0) == 0)
                begin
                    wait_results_done();
                end
                send_sample(pick_sample());
            end
        end
        wait_results_done();
        filt_sb.report_leftover();

        $display("covered %0d samples under four pacing mixes, %0d decimated results",
                 filt_sb.n_samples, filt_sb.n_checked);
        $display("%0d results clamped at full scale, %0d coefficient bank loads",
                 filt_sb.n_clamped, n_loads);
        if (filt_sb.n_errors == 0)
            $display("PASS fir_decimator_16tap_top");
        else
            $display("FAIL fir_decimator_16tap_top");
        $finish;
    end

endmodule

FILE: fir_decimator_16tap_top.f
hw/rtl/fir_dec_pkg.sv
hw/rtl/fir_dec_regs.sv
hw/rtl/fir_dec_hist.sv
hw/rtl/fir_dec_mac.sv
hw/rtl/fir_dec_seq.sv
hw/rtl/fir_decimator_16tap_top.sv
tb/sv/fir_dec_tb_pkg.sv
tb/sv/tb_top.sv
